// ===== hw/rtl/fpq16_pkg.sv =====
// Package with the constants, operation codes and pipeline type of the Q16.16 ALU.
`default_nettype none
package fpq16_pkg;

  localparam int DATA_W    = 32;
  localparam int FRAC_BITS = 16;
  localparam int NUM_W     = DATA_W + FRAC_BITS;
  localparam int DIV_STEPS = 4;
  localparam int NSTG      = (NUM_W + DIV_STEPS - 1) / DIV_STEPS;
  localparam int QW        = NSTG * DIV_STEPS;
  localparam int OP_W      = 3;
  localparam int IN_DATA_W  = 2 * DATA_W;
  localparam int OUT_DATA_W = ((DATA_W + 3 + 7) / 8) * 8;

  typedef enum logic [OP_W-1:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_NEG = 3'd4,
    OP_ABS = 3'd5,
    OP_CMP = 3'd6
  } op_e;

  typedef struct packed {
    logic                    vld;
    logic [OP_W-1:0]         op;
    logic [DATA_W-1:0]       a;
    logic [DATA_W-1:0]       b;
    logic [2*DATA_W-1:0]     prod;
    logic [QW-1:0]           num;
    logic [DATA_W-1:0]       rem;
    logic [QW-1:0]           quo;
    logic [DATA_W-1:0]       dmag;
    logic                    neg;
  } pipe_t;

endpackage
`default_nettype wire

// ===== hw/rtl/fixed_point_q16_alu.sv =====
// Pipelined signed Q16.16 fixed-point ALU with stream interfaces.
//
// The slave channel takes one operation per transaction: tuser carries the
// operation code and tdata carries operand A in the low word and operand B in
// the high word. The master channel returns one result transaction for each
// input transaction, in order, with the result and the compare and
// divide-by-zero flags in tdata.
//
// Every operation travels the same pipeline: one stage registers the operands
// and the 32 by 32 product, twelve stages each resolve four quotient bits of
// the restoring divider, and one output register holds the result. One
// transaction is accepted in every cycle while the receiver takes results.
//
// When the receiver stalls with a result waiting, the whole pipeline holds and
// s_axis_tready falls in the same cycle; nothing is dropped or repeated.
// Reset empties the pipeline and the output register.
`default_nettype none
module fixed_point_q16_alu import fpq16_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  // Fields from bit 0: operand_a[31:0], operand_b[31:0].
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
  // Fields from bit 0: operation[2:0].
  input  wire logic [OP_W-1:0]       s_axis_tuser,
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // Fields from bit 0: result[31:0], less_than, equal, div_by_zero, zero fill.
  output logic [OUT_DATA_W-1:0]      m_axis_tdata
);

  function automatic pipe_t div_stage(pipe_t p);
    pipe_t       r;
    logic [DATA_W:0] t;
    r = p;
    for (int i = 0; i < DIV_STEPS; i++) begin
      t     = {r.rem, r.num[QW-1]};
      r.num = {r.num[QW-2:0], 1'b0};
      if (t >= {1'b0, r.dmag}) begin
        t     = t - {1'b0, r.dmag};
        r.quo = {r.quo[QW-2:0], 1'b1};
      end else begin
        r.quo = {r.quo[QW-2:0], 1'b0};
      end
      r.rem = t[DATA_W-1:0];
    end
    return r;
  endfunction

  logic              adv;
  pipe_t             p_q [0:NSTG];
  pipe_t             in_d;
  logic [DATA_W-1:0] a_in;
  logic [DATA_W-1:0] b_in;
  logic [DATA_W-1:0] amag;
  logic              out_vld_q;
  logic [OUT_DATA_W-1:0] out_q;
  logic [OUT_DATA_W-1:0] out_d;
  logic [DATA_W-1:0] res;
  logic              lt;
  logic              eq;
  logic              dz;
  logic [DATA_W-1:0] qlo;
  pipe_t             fin;

  assign adv           = !out_vld_q || m_axis_tready;
  assign s_axis_tready = adv;
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_q;

  assign a_in = s_axis_tdata[DATA_W-1:0];
  assign b_in = s_axis_tdata[2*DATA_W-1:DATA_W];
  assign amag = a_in[DATA_W-1] ? (DATA_W'(0) - a_in) : a_in;

  always_comb begin
    in_d      = '0;
    in_d.vld  = s_axis_tvalid;
    in_d.op   = s_axis_tuser;
    in_d.a    = a_in;
    in_d.b    = b_in;
    in_d.prod = $signed(a_in) * $signed(b_in);
    in_d.num  = QW'({amag, {FRAC_BITS{1'b0}}}) << (QW - NUM_W);
    in_d.dmag = b_in[DATA_W-1] ? (DATA_W'(0) - b_in) : b_in;
    in_d.neg  = a_in[DATA_W-1] ^ b_in[DATA_W-1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_q[0] <= '0;
    end else if (adv) begin
      p_q[0] <= in_d;
    end
  end

  for (genvar k = 1; k <= NSTG; k++) begin : g_div
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        p_q[k] <= '0;
      end else if (adv) begin
        p_q[k] <= div_stage(p_q[k-1]);
      end
    end
  end

  always_comb begin
    fin = p_q[NSTG];
    res = '0;
    lt  = 1'b0;
    eq  = 1'b0;
    dz  = 1'b0;
    qlo = fin.quo[DATA_W-1:0];
    unique case (op_e'(fin.op))
      OP_ADD: res = fin.a + fin.b;
      OP_SUB: res = fin.a - fin.b;
      OP_MUL: res = fin.prod[FRAC_BITS +: DATA_W];
      OP_DIV: begin
        if (fin.b == '0) begin
          dz = 1'b1;
        end else begin
          res = fin.neg ? (DATA_W'(0) - qlo) : qlo;
        end
      end
      OP_NEG: res = DATA_W'(0) - fin.a;
      OP_ABS: res = fin.a[DATA_W-1] ? (DATA_W'(0) - fin.a) : fin.a;
      OP_CMP: begin
        lt = $signed(fin.a) < $signed(fin.b);
        eq = fin.a == fin.b;
      end
      default: res = '0;
    endcase
    out_d = OUT_DATA_W'({dz, eq, lt, res});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
      out_q     <= '0;
    end else if (adv) begin
      out_vld_q <= fin.vld;
      out_q     <= out_d;
    end
  end

endmodule
`default_nettype wire

// ===== tb/fixed_point_q16_alu_checker.sv =====
// Checker that predicts Q16.16 ALU results from the input channel and compares the output channel.
`timescale 1ns / 100ps
module fixed_point_q16_alu_checker import fpq16_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  s_axis_tvalid,
  input  wire logic                  s_axis_tready,
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
  input  wire logic [OP_W-1:0]       s_axis_tuser,
  input  wire logic                  m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  input  wire logic [OUT_DATA_W-1:0] m_axis_tdata,
  output int                         fail_count_o,
  output int                         pending_o
);

  typedef struct packed {
    logic [DATA_W-1:0] result;
    logic              less_than;
    logic              equal;
    logic              div_by_zero;
  } alu_out_t;

  alu_out_t expected_q[$];

  function automatic alu_out_t alu_predict(logic [OP_W-1:0] op, logic signed [31:0] a,
                                           logic signed [31:0] b);
    alu_out_t r;
    logic signed [63:0] prod;
    logic signed [63:0] num;
    logic signed [63:0] quo;
    r = '0;
    case (op)
      OP_ADD: r.result = a + b;
      OP_SUB: r.result = a - b;
      OP_MUL: begin
        prod = 64'(a) * 64'(b);
        r.result = 32'(prod >>> FRAC_BITS);
      end
      OP_DIV: begin
        if (b == 0) begin
          r.div_by_zero = 1'b1;
        end else begin
          num = 64'(a) <<< FRAC_BITS;
          quo = num / 64'(b);
          r.result = quo[31:0];
        end
      end
      OP_NEG: r.result = -a;
      OP_ABS: r.result = (a < 0) ? -a : a;
      OP_CMP: begin
        r.less_than = a < b;
        r.equal = a == b;
      end
      default: r = '0;
    endcase
    return r;
  endfunction

  assign pending_o = expected_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    alu_out_t exp_r;
    if (!rst_ni) begin
      fail_count_o <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready)
        expected_q.push_back(alu_predict(s_axis_tuser, s_axis_tdata[31:0], s_axis_tdata[63:32]));
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_q.size() == 0) begin
          $error("unexpected result transaction %h", m_axis_tdata);
          fail_count_o <= fail_count_o + 1;
        end else begin
          exp_r = expected_q.pop_front();
          if (m_axis_tdata[31:0] !== exp_r.result ||
              m_axis_tdata[32] !== exp_r.less_than ||
              m_axis_tdata[33] !== exp_r.equal ||
              m_axis_tdata[34] !== exp_r.div_by_zero)
            fail_count_o <= fail_count_o + 1;
          if (m_axis_tdata[31:0] !== exp_r.result)
            $error("result expected %h actual %h", exp_r.result, m_axis_tdata[31:0]);
          if (m_axis_tdata[32] !== exp_r.less_than)
            $error("less_than expected %b actual %b", exp_r.less_than, m_axis_tdata[32]);
          if (m_axis_tdata[33] !== exp_r.equal)
            $error("equal expected %b actual %b", exp_r.equal, m_axis_tdata[33]);
          if (m_axis_tdata[34] !== exp_r.div_by_zero)
            $error("div_by_zero expected %b actual %b", exp_r.div_by_zero, m_axis_tdata[34]);
        end
      end
    end
  end

endmodule

// ===== tb/fixed_point_q16_alu_tb.sv =====
// Top of the Q16.16 ALU testbench: clock, reset, stimulus, receiver stalls and verdict.
`timescale 1ns / 100ps
module fixed_point_q16_alu_tb import fpq16_pkg::*;;

  localparam int NUM_RANDOM = 1750;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic [OP_W-1:0]       s_axis_tuser = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  int                    fail_count;
  int                    pending;
  bit                    calm_phase = 1'b0;
  bit                    hold_receiver = 1'b0;

  always #5 clk_i = ~clk_i;

  fixed_point_q16_alu u_top (.*);

  fixed_point_q16_alu_checker u_checker (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  function automatic logic [31:0] pick_operand();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return '0;
      3: return 32'(signed'($urandom_range(0, 8)) - 4) << 16;
      4: return 32'(signed'($urandom_range(0, 2000)) - 1000);
      5: return {{16{$urandom_range(0, 1) == 1}}, 16'($urandom)};
      default: return $urandom;
    endcase
  endfunction

  task automatic send_op(logic [OP_W-1:0] op, logic [31:0] a, logic [31:0] b);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {b, a};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic sender_gap();
    if (!calm_phase && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk_i);
    end
  endtask

  always begin
    @(negedge clk_i);
    if (hold_receiver) begin
      m_axis_tready <= 1'b0;
      repeat (100) @(negedge clk_i);
      hold_receiver = 1'b0;
    end else if (!calm_phase && $urandom_range(0, 7) == 0) begin
      m_axis_tready <= 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk_i);
    end
    m_axis_tready <= rst_ni;
  end

  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end

  initial begin
    logic [31:0] edges [4];
    edges = '{32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'hffff_ffff};
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    for (int op = 0; op < 8; op++)
      send_op(OP_W'(op), 32'h0003_8000, 32'hfffe_4000);
    for (int i = 0; i < 4; i++)
      send_op(OP_MUL, edges[i], edges[3 - i]);
    send_op(OP_DIV, 32'h0001_0000, 32'h0);
    send_op(OP_DIV, 32'h8000_0000, 32'hffff_ffff);
    send_op(OP_DIV, 32'h7fff_ffff, 32'h0000_0001);
    send_op(OP_NEG, 32'h8000_0000, 32'hffff_ffff);
    send_op(OP_ABS, 32'h8000_0000, 32'h0);
    send_op(OP_CMP, 32'h8000_0000, 32'h7fff_ffff);
    send_op(OP_CMP, 32'h1234_5678, 32'h1234_5678);
    send_op(OP_ADD, 32'h7fff_ffff, 32'h0000_0001);
    send_op(OP_SUB, 32'h8000_0000, 32'h0000_0001);
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    hold_receiver = 1'b1;
    for (int i = 0; i < 40; i++)
      send_op(3'($urandom_range(0, 7)), pick_operand(), pick_operand());
    for (int i = 0; i < NUM_RANDOM; i++) begin
      if (i == NUM_RANDOM - 200) calm_phase = 1'b1;
      sender_gap();
      send_op(3'($urandom_range(0, 7)), pick_operand(),
              $urandom_range(0, 30) == 0 ? 32'h0 : pick_operand());
    end
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (30) @(negedge clk_i);
    if (fail_count == 0 && pending == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

// ===== fixed_point_q16_alu.f =====
hw/rtl/fpq16_pkg.sv
hw/rtl/fixed_point_q16_alu.sv
tb/fixed_point_q16_alu_checker.sv
tb/fixed_point_q16_alu_tb.sv
